@@ hdl/jhs_pkg.sv @@
// Shared types and constants for the Jacobi five-point stencil sweep.
// No dependencies; every other file imports this package.

package jhs_pkg;

   localparam int CELL_W       = 32;
   localparam int COLS_W       = 10;
   localparam int ROWS_W       = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int DEF_MAX_COLS = 512;
   localparam int QUEUE_DEPTH  = 4;
   localparam int MIN_SIZE     = 3;
   localparam int FIRST_INNER  = 2;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE    = 2'd2;

   localparam logic [COLS_W-1:0] RST_GRID_COLUMNS = 10'd500;
   localparam logic [ROWS_W-1:0] RST_GRID_ROWS    = 16'd500;
   localparam logic [CELL_W-1:0] RST_TOLERANCE    = 32'd17;

   typedef logic [CELL_W-1:0] cell_type;

   typedef struct packed {
      logic [COLS_W-1:0] grid_columns;
      logic [ROWS_W-1:0] grid_rows;
   } jhs_size_type;

   // one interior result on its way from front to back
   typedef struct packed {
      cell_type new_value;
      cell_type old_value;
      logic     sweep_done;
      logic     restart;
   } jhs_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jhs_qstat_type;

endpackage

@@ hdl/jhs_ifs.sv @@
// Valid/ready channel interfaces for the stencil sweep: cells in, results out, csr writes.
// Depends on jhs_pkg.

interface jhs_req_if;
   import jhs_pkg::*;
   logic     valid;
   logic     ready;
   cell_type cell_value;
   modport source (output valid, output cell_value, input ready);
   modport sink (input valid, input cell_value, output ready);
endinterface

interface jhs_rsp_if;
   import jhs_pkg::*;
   logic     valid;
   logic     ready;
   cell_type new_value;
   logic     sweep_done;
   cell_type max_change;
   logic     converged;
   modport source (output valid, output new_value, output sweep_done,
                   output max_change, output converged, input ready);
   modport sink (input valid, input new_value, input sweep_done,
                 input max_change, input converged, output ready);
endinterface

interface jhs_csr_if;
   import jhs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CELL_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/jhs_front.sv @@
// Front end: raster counters, the two line stores and the five-point window; classifies
// each cell and forms the stencil average of interior cells. Depends on jhs_pkg.

module jhs_front #(
   parameter int MAX_COLS = jhs_pkg::DEF_MAX_COLS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  jhs_pkg::jhs_size_type  sizes,
   input  logic                   accept,
   input  jhs_pkg::cell_type      cell_value,
   output logic                   push,
   output jhs_pkg::jhs_entry_type entry
);
   import jhs_pkg::*;

   localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int EW = (IW + 1 > COLS_W) ? IW + 1 : COLS_W;
   localparam logic [EW-1:0] COLS_HI = EW'(MAX_COLS);
   localparam logic [EW-1:0] COLS_LO = EW'(MIN_SIZE);
   localparam logic [ROWS_W-1:0] ROWS_LO = ROWS_W'(MIN_SIZE);

   cell_type upper_mem  [MAX_COLS];
   cell_type middle_mem [MAX_COLS];

   logic [IW-1:0]     col_ff, col_in;
   logic [ROWS_W-1:0] row_ff, row_in;
   logic              pending_ff, pending_in;
   cell_type          rd_up_ff, rd_mid_ff;
   cell_type          w_top_ff, w_ctr_ff, w_left_ff, w_bot_ff;

   logic [EW-1:0]       cols_eff, col_ext, cols_req;
   logic [ROWS_W-1:0]   rows_eff;
   logic                col_last, row_last, interior, sweep_end;
   logic [CELL_W+1:0]   sum;

   always_comb begin
      cols_req = EW'(sizes.grid_columns);
      if (cols_req < COLS_LO) begin
         cols_eff = COLS_LO;
      end else if (cols_req > COLS_HI) begin
         cols_eff = COLS_HI;
      end else begin
         cols_eff = cols_req;
      end
      rows_eff = (sizes.grid_rows < ROWS_LO) ? ROWS_LO : sizes.grid_rows;
      col_ext  = EW'(col_ff);
      col_last = col_ext >= cols_eff - EW'(1);
      row_last = row_ff >= rows_eff - ROWS_W'(1);
      interior = (row_ff >= ROWS_W'(FIRST_INNER)) && (col_ext >= EW'(FIRST_INNER))
                 && (row_ff < rows_eff) && (col_ext < cols_eff);
      sweep_end = col_last && row_last;

      sum = (CELL_W+2)'(w_top_ff) + (CELL_W+2)'(rd_mid_ff)
          + (CELL_W+2)'(w_left_ff) + (CELL_W+2)'(w_bot_ff);

      push             = accept && interior;
      entry.new_value  = sum[CELL_W+1:2];
      entry.old_value  = w_ctr_ff;
      entry.sweep_done = (row_ff == rows_eff - ROWS_W'(1)) && (col_ext == cols_eff - EW'(1));
      entry.restart    = pending_ff;

      col_in     = col_ff;
      row_in     = row_ff;
      pending_in = pending_ff;
      if (reset) begin
         col_in     = '0;
         row_in     = '0;
         pending_in = 1'b0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROWS_W'(1);
         end else begin
            col_in = col_ff + IW'(1);
         end
         // the first result after a sweep wrap starts a fresh maximum
         if (sweep_end) begin
            pending_in = 1'b1;
         end else if (interior) begin
            pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff     <= col_in;
      row_ff     <= row_in;
      pending_ff <= pending_in;
   end

   // read ahead at the next column so the data waits in a register for the next cell
   always_ff @(posedge clock) begin
      if (accept) begin
         upper_mem[col_ff]  <= rd_mid_ff;
         middle_mem[col_ff] <= cell_value;
      end
      rd_up_ff  <= upper_mem[col_in];
      rd_mid_ff <= middle_mem[col_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_top_ff  <= '0;
         w_ctr_ff  <= '0;
         w_left_ff <= '0;
         w_bot_ff  <= '0;
      end else if (accept) begin
         w_left_ff <= w_ctr_ff;
         w_ctr_ff  <= rd_mid_ff;
         w_top_ff  <= rd_up_ff;
         w_bot_ff  <= cell_value;
      end
   end

endmodule

@@ hdl/jhs_queue.sv @@
// Short FIFO of interior results between front and back.
// Depends on jhs_pkg.

module jhs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  jhs_pkg::jhs_entry_type push_entry,
   input  logic                   pop,
   output jhs_pkg::jhs_entry_type head,
   output jhs_pkg::jhs_qstat_type stat
);
   import jhs_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   jhs_entry_type slots_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      stat.full  = count_ff == CW'(QUEUE_DEPTH);
      stat.empty = count_ff == '0;
      head       = slots_ff[rd_ff];

      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/jhs_back.sv @@
// Back end: absolute change, running maximum over the sweep and the result register.
// Depends on jhs_pkg and jhs_rsp_if.

module jhs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  jhs_pkg::cell_type      tolerance,
   input  jhs_pkg::jhs_entry_type head,
   input  jhs_pkg::jhs_qstat_type stat,
   output logic                   pop,
   jhs_rsp_if.source              rsp
);
   import jhs_pkg::*;

   logic     s1_valid_ff, s1_done_ff, s1_restart_ff;
   cell_type s1_diff_ff, s1_value_ff;
   logic     out_valid_ff, out_done_ff, out_conv_ff;
   cell_type out_value_ff, out_max_ff;
   cell_type max_ff;

   logic     s1_load, s2_load, advance;
   cell_type diff, max_base, max_new;

   always_comb begin
      s2_load  = !out_valid_ff || rsp.ready;
      s1_load  = !s1_valid_ff || s2_load;
      pop      = !stat.empty && s1_load;
      advance  = s1_valid_ff && s2_load;
      diff     = (head.new_value >= head.old_value) ? head.new_value - head.old_value
                                                    : head.old_value - head.new_value;
      max_base = s1_restart_ff ? '0 : max_ff;
      max_new  = (s1_diff_ff > max_base) ? s1_diff_ff : max_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_ff       <= '0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= pop;
         end
         if (s2_load) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (advance) begin
            max_ff <= max_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_diff_ff    <= diff;
         s1_value_ff   <= head.new_value;
         s1_done_ff    <= head.sweep_done;
         s1_restart_ff <= head.restart;
      end
      if (advance) begin
         out_value_ff <= s1_value_ff;
         out_done_ff  <= s1_done_ff;
         out_max_ff   <= s1_done_ff ? max_new : '0;
         out_conv_ff  <= s1_done_ff && (max_new < tolerance);
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.new_value  = out_value_ff;
   assign rsp.sweep_done = out_done_ff;
   assign rsp.max_change = out_max_ff;
   assign rsp.converged  = out_conv_ff;

endmodule

@@ hdl/jacobi_heat_stencil_sweep.sv @@
// Top level of the Jacobi five-point stencil sweep: csr registers, front, queue, back.
// Depends on jhs_pkg, jhs_ifs, jhs_front, jhs_queue and jhs_back.
//
//   channel  dir  payload                                         handshake
//   req_ch   in   cell_value                                      valid/ready
//   rsp_ch   out  new_value, sweep_done, max_change, converged    valid/ready
//   csr_ch   in   index, data (grid_columns, grid_rows, tolerance) valid/ready, always ready
//
// One cell per cycle sustained while the result queue is not full.
// The line store read for the next column is issued in the same cycle as the write
// for the current one, at a different address, so each store needs one read port and
// one write port and never limits the rate.
// Reset is synchronous: counters, window, running maximum and queue clear; line
// stores keep their contents. req_ch.ready drops only while the four-entry result
// queue is full, which takes a stalled rsp_ch.

module jacobi_heat_stencil_sweep #(
   parameter int MAX_COLS = jhs_pkg::DEF_MAX_COLS
) (
   input logic     clock,
   input logic     reset,
   jhs_req_if.sink req_ch,
   jhs_rsp_if.source rsp_ch,
   jhs_csr_if.sink csr_ch
);
   import jhs_pkg::*;

   jhs_size_type  sizes_ff;
   cell_type      tol_ff;
   logic          accept, push, pop;
   jhs_entry_type entry, head;
   jhs_qstat_type qstat;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sizes_ff.grid_columns <= RST_GRID_COLUMNS;
         sizes_ff.grid_rows    <= RST_GRID_ROWS;
         tol_ff                <= RST_TOLERANCE;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_GRID_COLUMNS: sizes_ff.grid_columns <= csr_ch.data[COLS_W-1:0];
            CSR_GRID_ROWS:    sizes_ff.grid_rows    <= csr_ch.data[ROWS_W-1:0];
            CSR_TOLERANCE:    tol_ff                <= csr_ch.data;
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   assign req_ch.ready = !qstat.full;
   assign accept       = req_ch.valid && !qstat.full;

   jhs_front #(
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .sizes      (sizes_ff),
      .accept     (accept),
      .cell_value (req_ch.cell_value),
      .push       (push),
      .entry      (entry)
   );

   jhs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .stat       (qstat)
   );

   jhs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tolerance (tol_ff),
      .head      (head),
      .stat      (qstat),
      .pop       (pop),
      .rsp       (rsp_ch)
   );

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_summary_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.sweep_done |-> rsp_ch.max_change == '0 && !rsp_ch.converged)
      else $error("sweep summary on a result that does not end the sweep");

   a_converged_below_tol: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.converged |-> rsp_ch.max_change < tol_ff)
      else $error("converged flagged with max change at or above tolerance");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop)
      else $error("result queue popped while empty");

endmodule

@@ test/jacobi_heat_stencil_sweep_test.sv @@
// Testbench for jacobi_heat_stencil_sweep: streams grids of cells, predicts every interior result
// with its own stencil tracker and checks each result field against it.
// Depends on jhs_pkg, jhs_ifs and the block itself.

module jacobi_heat_stencil_sweep_test;
   import jhs_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam cell_type CELL_MAX      = '1;
   localparam int unsigned RANDOM_CELLS  = 614;
   localparam int unsigned QUIET_CELLS   = 100;
   localparam int unsigned PHASE_CAP     = 200;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RUN_LIMIT     = 2_000_000;

   typedef struct {
      cell_type new_value;
      logic     sweep_done;
      cell_type max_change;
      logic     converged;
   } sweep_result_type;

   class stencil_scoreboard;
      cell_type         row_above[DEF_MAX_COLS];
      cell_type         row_current[DEF_MAX_COLS];
      cell_type         nb_top, nb_mid, nb_left, nb_bottom;
      int unsigned      col_at, row_at;
      cell_type         peak;
      logic [COLS_W-1:0] columns_cfg;
      logic [ROWS_W-1:0] rows_cfg;
      cell_type         tol_cfg;
      sweep_result_type due_results[$];
      int unsigned      errors;
      int unsigned      checked;

      function new();
         foreach (row_above[k]) begin
            row_above[k] = '0;
            row_current[k] = '0;
         end
         nb_top = '0;
         nb_mid = '0;
         nb_left = '0;
         nb_bottom = '0;
         col_at = 0;
         row_at = 0;
         peak = '0;
         columns_cfg = RST_GRID_COLUMNS;
         rows_cfg = RST_GRID_ROWS;
         tol_cfg = RST_TOLERANCE;
         errors = 0;
         checked = 0;
      endfunction

      function int unsigned active_columns();
         if (columns_cfg < MIN_SIZE) return MIN_SIZE;
         if (columns_cfg > DEF_MAX_COLS) return DEF_MAX_COLS;
         return columns_cfg;
      endfunction

      function int unsigned active_rows();
         return (rows_cfg < MIN_SIZE) ? MIN_SIZE : rows_cfg;
      endfunction

      // mid-sweep the width may only hold or shrink, so no line entry is read unwritten
      function bit columns_may_change(logic [COLS_W-1:0] value);
         int unsigned wanted;
         wanted = (value < MIN_SIZE) ? MIN_SIZE :
                  (value > DEF_MAX_COLS) ? DEF_MAX_COLS : value;
         return (col_at == 0 && row_at == 0) || wanted <= active_columns();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, cell_type data);
         case (index)
            CSR_GRID_COLUMNS: columns_cfg = data[COLS_W-1:0];
            CSR_GRID_ROWS:    rows_cfg = data[ROWS_W-1:0];
            CSR_TOLERANCE:    tol_cfg = data;
            default: ;
         endcase
      endfunction

      // cells still to come before both counters wrap to the start of a sweep
      function int unsigned cells_to_sweep_end();
         int unsigned cols, rows, left_in_row;
         cols = active_columns();
         rows = active_rows();
         left_in_row = (col_at >= cols - 1) ? 1 : cols - col_at;
         if (row_at >= rows - 1) return left_in_row;
         return left_in_row + (rows - 1 - row_at) * cols;
      endfunction

      function void take_cell(cell_type value);
         int unsigned      cols, rows, slot;
         cell_type         above, right_nb, fresh, change;
         logic [CELL_W+1:0] total;
         sweep_result_type due;
         cols = active_columns();
         rows = active_rows();
         slot = col_at % DEF_MAX_COLS;
         above = row_above[slot];
         right_nb = row_current[slot];
         if (row_at >= FIRST_INNER && col_at >= FIRST_INNER && row_at < rows && col_at < cols) begin
            total = (CELL_W+2)'(nb_top) + (CELL_W+2)'(right_nb)
                  + (CELL_W+2)'(nb_left) + (CELL_W+2)'(nb_bottom);
            fresh = total[CELL_W+1:2];
            change = (fresh >= nb_mid) ? fresh - nb_mid : nb_mid - fresh;
            if (change > peak) peak = change;
            due.new_value = fresh;
            if (row_at == rows - 1 && col_at == cols - 1) begin
               due.sweep_done = 1'b1;
               due.max_change = peak;
               due.converged = (peak < tol_cfg);
            end else begin
               due.sweep_done = 1'b0;
               due.max_change = '0;
               due.converged = 1'b0;
            end
            due_results.push_back(due);
         end
         row_above[slot] = right_nb;
         row_current[slot] = value;
         nb_left = nb_mid;
         nb_mid = right_nb;
         nb_top = above;
         nb_bottom = value;
         // a counter at or past the last index wraps at the end of this cell
         if (col_at >= cols - 1) begin
            col_at = 0;
            if (row_at >= rows - 1) begin
               row_at = 0;
               peak = '0;
            end else begin
               row_at = row_at + 1;
            end
         end else begin
            col_at = col_at + 1;
         end
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at result %0d: %s", checked, what);
         errors++;
      endtask

      task check_result(sweep_result_type got);
         sweep_result_type want;
         checked++;
         if (due_results.size() == 0) begin
            report_mismatch("result transaction with nothing expected");
            return;
         end
         want = due_results.pop_front();
         if (got.new_value !== want.new_value)
            report_mismatch($sformatf("new_value %h, expected %h", got.new_value, want.new_value));
         if (got.sweep_done !== want.sweep_done)
            report_mismatch($sformatf("sweep_done %b, expected %b", got.sweep_done,
                                      want.sweep_done));
         if (got.max_change !== want.max_change)
            report_mismatch($sformatf("max_change %h, expected %h", got.max_change,
                                      want.max_change));
         if (got.converged !== want.converged)
            report_mismatch($sformatf("converged %b, expected %b", got.converged,
                                      want.converged));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   req_gaps_on = 1'b1;
   bit   rsp_stalls_on = 1'b1;
   bit   tail_quiet = 1'b0;
   int unsigned random_cells = 0;

   stencil_scoreboard tally = new();

   jhs_req_if req_ch ();
   jhs_rsp_if rsp_ch ();
   jhs_csr_if csr_ch ();

   jacobi_heat_stencil_sweep dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_cell(input cell_type value);
      int unsigned idle;
      idle = 0;
      if (req_gaps_on && !tail_quiet && $urandom_range(0, 9) == 0) idle = $urandom_range(1, 19);
      repeat (idle) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.cell_value <= value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tally.take_cell(value);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input cell_type data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      tally.write_reg(index, data);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // drain all results, then let the clock idle so nothing is left in flight
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tally.due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_stalls_on && !tail_quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watch_results
      sweep_result_type got;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.new_value = rsp_ch.new_value;
         got.sweep_done = rsp_ch.sweep_done;
         got.max_change = rsp_ch.max_change;
         got.converged = rsp_ch.converged;
         tally.check_result(got);
      end
   end

   initial begin
      int unsigned remaining, count, style;
      cell_type    base, word;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cell_value = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_GRID_COLUMNS;
      csr_ch.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // undersized registers act as 3x3; a hot ring around a cold center gives the
      // largest possible change, which is not below even the largest tolerance
      write_csr(CSR_GRID_COLUMNS, 32'd0);
      write_csr(CSR_GRID_ROWS, 32'd1);
      write_csr(CSR_TOLERANCE, CELL_MAX);
      for (int k = 0; k < 9; k++) send_cell((k % 2 == 1) ? CELL_MAX : '0);
      settle();

      // maximum change equal to the tolerance must not count as converged
      write_csr(CSR_GRID_COLUMNS, 32'd4);
      write_csr(CSR_GRID_ROWS, 32'd2);
      write_csr(CSR_TOLERANCE, 32'd1);
      for (int k = 0; k < 12; k++) send_cell((k == 1) ? 32'd4 : '0);
      settle();

      // largest row count, cut short mid-sweep; upper data bits are ignored
      write_csr(CSR_GRID_COLUMNS, 32'hFFFF_FC03);
      write_csr(CSR_GRID_ROWS, 32'h1234_FFFF);
      write_csr(CSR_TOLERANCE, $urandom);
      repeat (12) send_cell($urandom);
      settle();
      write_csr(CSR_GRID_ROWS, 32'd5);
      repeat (3) send_cell($urandom);
      settle();

      while (random_cells < RANDOM_CELLS) begin
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(0, 3)) begin
            word = $urandom;
            case ($urandom_range(0, 3))
               0: begin
                  word[COLS_W-1:0] = COLS_W'(($urandom_range(0, 19) == 0) ?
                                             $urandom_range(513, 1023) :
                                             ($urandom_range(0, 7) == 0) ?
                                             $urandom_range(0, 2) :
                                             $urandom_range(3, 12));
                  if (tally.columns_may_change(word[COLS_W-1:0]))
                     write_csr(CSR_GRID_COLUMNS, word);
               end
               1: begin
                  word[ROWS_W-1:0] = ROWS_W'(($urandom_range(0, 19) == 0) ?
                                             $urandom_range(9, 65535) :
                                             ($urandom_range(0, 7) == 0) ?
                                             $urandom_range(0, 2) :
                                             $urandom_range(3, 8));
                  write_csr(CSR_GRID_ROWS, word);
               end
               2: begin
                  case ($urandom_range(0, 4))
                     0: word = '0;
                     1: word = CELL_MAX;
                     2: word = RST_TOLERANCE;
                     3: word = $urandom_range(0, 64);
                     default: ;
                  endcase
                  write_csr(CSR_TOLERANCE, word);
               end
               default: write_csr(CSR_UNUSED, word);
            endcase
         end

         // mostly run to the end of the sweep; sometimes stop part way
         remaining = tally.cells_to_sweep_end();
         count = remaining;
         if (count > PHASE_CAP || $urandom_range(0, 4) == 0)
            count = $urandom_range(1, (count > PHASE_CAP) ? PHASE_CAP : count);
         style = $urandom_range(0, 3);
         base = $urandom;
         repeat (count) begin
            case (style)
               0: word = $urandom;
               1: word = ($urandom_range(0, 2) == 0) ? '0 :
                         ($urandom_range(0, 1) == 0) ? CELL_MAX : $urandom;
               2: word = base + $urandom_range(0, 15);
               default: word = $urandom_range(0, 255);
            endcase
            send_cell(word);
            random_cells++;
            if (random_cells >= RANDOM_CELLS - QUIET_CELLS) tail_quiet = 1'b1;
         end
         settle();
      end

      if (tally.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
